// File: src/particle_emitter_update_top_assert.svh
// Assertion macros shared by the particle emitter RTL.
// Depends on a clk_i clock and an active-low rst_ni reset in the including module.
`ifndef PARTICLE_EMITTER_UPDATE_TOP_ASSERT_SVH
`define PARTICLE_EMITTER_UPDATE_TOP_ASSERT_SVH

// Invariant that must hold at every clock edge out of reset.
`define PTCL_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication.
`define PTCL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/ptcl_pkg.sv
// Shared types, constants and helper functions of the particle emitter.
// No dependencies; the top level imports this package.
package ptcl_pkg;

  localparam int PART_SLOTS = 64;
  localparam int IDX_W = $clog2(PART_SLOTS);
  localparam int CNT_W = $clog2(PART_SLOTS + 1);

  localparam logic [63:0] LCG_MUL  = 64'd6364136223846793005;
  localparam logic [63:0] LCG_ADD  = 64'd1442695040888963407;
  localparam logic [63:0] SEED_MUL = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SEED_ADD = 64'hDEADBEEF12345678;
  localparam logic [47:0] ONE_Q16  = 48'h0000_0001_0000;
  localparam logic [47:0] DEBT_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  typedef enum logic [2:0] {
    CFG_EMIT_RATE  = 3'd0,
    CFG_CAP        = 3'd1,
    CFG_SPEED_LOW  = 3'd2,
    CFG_SPEED_HIGH = 3'd3,
    CFG_LIFE_LOW   = 3'd4,
    CFG_LIFE_HIGH  = 3'd5,
    CFG_GRAVITY    = 3'd6,
    CFG_EMITTER_ID = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] dt;
    logic               emitting;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        life_fraction;
    logic [CNT_W-1:0]   alive_total;
    logic               present;
    logic               last;
  } out_t;

  // One particle as held in the state memory.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] age;
    logic signed [31:0] life;
  } part_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sh0_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -50'sh0_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [49:0] sext50(input logic signed [31:0] v);
    return {{18{v[31]}}, v};
  endfunction

endpackage

// File: src/ptcl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ptcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ptcl_mul.sv
// Shared 33x33 signed multiplier with a registered product.
// Unsigned 32-bit operands are passed zero-extended. No dependencies.
module ptcl_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: src/ptcl_div.sv
// Restoring divider for the life fraction: (num << 16) / den, with num < den.
// One quotient bit per cycle. Depends on nothing but its ports.
module ptcl_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] num_i,
  input  logic [30:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [15:0] quot_o
);

  logic [30:0] rem_q;
  logic [30:0] den_q;
  logic [15:0] quot_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [31:0] shifted;
  logic [31:0] diff;
  logic        take;

  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};
  assign take    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The partial remainder always stays below the divisor, so it fits 31 bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= take ? diff[30:0] : shifted[30:0];
      quot_q <= {quot_q[14:0], take};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: src/particle_emitter_update_top.sv
// Top level of the particle emitter: configuration, tick sequencer, state memory.
// Depends on ptcl_pkg, ptcl_ram, ptcl_mul, ptcl_div and the assertion header.

// One input transaction is one simulation tick of a single emitter. The block then
// ages and culls its live particles in order, spawns new ones from a 64-bit LCG,
// applies gravity and motion, and sends one output transaction per live particle
// (or a single transaction with present low when none is alive), the final one
// flagged by last. The input is not ready again until the last result of the tick
// has been loaded into the output register. All particle state lives in one
// 64-entry by 256-bit memory with one write and one registered read port, and all
// products go through one shared 33x33 multiplier, so a tick runs as a sequence:
// accepting the tick, seeding on the first tick only, a read and a write step per
// particle for the cull pass and a step to close it, the debt update, for each
// spawned particle a check, four generator steps, two range draws and the jitter
// products with the write, a step to end spawning, the gravity term, and for each
// reported particle the read, motion and output steps with a division when the
// life fraction needs one. The output side can stall each report.
// The state memory has no reset; the live count alone says which entries hold
// particles. Configuration must only be written while the block is idle.
module particle_emitter_update_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [31:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ptcl_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ptcl_pkg::out_t  out_data_o
);
  import ptcl_pkg::*;

  `include "particle_emitter_update_top_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE, S_SEED0, S_SEED1, S_SEED2, S_CULL_RD, S_CULL_WR, S_DEBT0, S_DEBT1,
    S_SPAWN, S_L0, S_L1, S_L2, S_L3, S_R0, S_R1, S_J0, S_J1, S_J2,
    S_GRAV0, S_GRAV1, S_M_RD, S_M0, S_M1, S_M2, S_M3, S_M4, S_DIVW, S_M_OUT,
    S_EMPTY
  } state_e;

  // Order of the generator draws for one spawned particle.
  typedef enum logic [1:0] {D_SPEED, D_JX, D_JZ, D_LIFE} draw_e;

  // Configuration registers.
  logic signed [31:0] rate_q, spd_lo_q, spd_hi_q, life_lo_q, life_hi_q, grav_q;
  logic [6:0]         cap_q;
  logic [31:0]        id_q;

  // Persistent emitter state.
  logic [CNT_W-1:0] live_q;
  logic [47:0]      debt_q;
  logic [63:0]      rng_q;
  logic             seeded_q;

  // Per-tick working registers.
  state_e             state_q;
  draw_e              draw_q;
  logic signed [31:0] dt_q;
  logic               emit_q;
  logic signed [31:0] ox_q, oy_q, oz_q;
  logic [CNT_W-1:0]   i_q, k_q;
  logic [63:0]        acc_q;
  logic signed [31:0] speed_q, life_q, vx_q;
  logic signed [24:0] jx_q, jz_q;
  logic signed [47:0] gdy_q;
  part_t              ent_q;
  logic [16:0]        frac_q;

  logic   out_valid_q;
  out_t   out_q;
  logic   out_free;
  logic   out_load;
  out_t   out_d;
  part_t  ent_ld;

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  // State memory ports.
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  part_t            ram_wdata, ram_rdata;

  // Divider.
  logic        div_start, div_busy, div_done;
  logic [15:0] div_quot;

  // Derived values.
  logic [CNT_W-1:0]   cap_eff;
  logic signed [31:0] rate_eff;
  logic signed [31:0] rlo, rhi, rng_val;
  logic signed [32:0] rspan;
  logic [63:0]        rng_next;
  logic [23:0]        unit_next;
  logic signed [31:0] cull_age;
  logic [48:0]        debt_sum;
  part_t              spawn_ent;

  assign cap_eff  = (cap_q > 7'(PART_SLOTS)) ? CNT_W'(PART_SLOTS) : CNT_W'(cap_q);
  assign rate_eff = (emit_q && rate_q > 32'sd0) ? rate_q : 32'sd0;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free && (state_q == S_M_OUT || state_q == S_EMPTY);

  // Range bounds for the current draw, swapped when given in reverse.
  always_comb begin
    logic signed [31:0] a, b;
    a = (draw_q == D_LIFE) ? life_lo_q : spd_lo_q;
    b = (draw_q == D_LIFE) ? life_hi_q : spd_hi_q;
    rlo = (b < a) ? b : a;
    rhi = (b < a) ? a : b;
  end
  assign rspan   = {rhi[31], rhi} - {rlo[31], rlo};
  assign rng_val = rlo + prod[55:24];

  // Last partial product of a generator step completes the new state.
  assign rng_next  = acc_q + {prod[31:0], 32'd0} + LCG_ADD;
  assign unit_next = rng_next[63:40];

  assign cull_age = sat32(sext50(ram_rdata.age) + sext50(dt_q));
  assign debt_sum = {1'b0, debt_q} + {1'b0, prod[63:16]};

  always_comb begin
    spawn_ent       = '0;
    spawn_ent.pos_x = ox_q;
    spawn_ent.pos_y = oy_q;
    spawn_ent.pos_z = oz_q;
    spawn_ent.vel_x = vx_q;
    spawn_ent.vel_y = speed_q;
    spawn_ent.vel_z = prod[56:25];
    spawn_ent.age   = 32'sd0;
    spawn_ent.life  = life_q;
  end

  // Particle as loaded for the motion pass, with gravity already applied.
  always_comb begin
    ent_ld       = ram_rdata;
    ent_ld.vel_y = sat32(sext50(ram_rdata.vel_y) + {{2{gdy_q[47]}}, gdy_q});
  end

  // Next output transaction: a particle report, or the empty-emitter marker.
  always_comb begin
    out_d = '0;
    if (state_q == S_EMPTY) begin
      out_d.last = 1'b1;
    end else begin
      out_d.slot          = i_q[IDX_W-1:0];
      out_d.pos_x         = ent_q.pos_x;
      out_d.pos_y         = ent_q.pos_y;
      out_d.pos_z         = ent_q.pos_z;
      out_d.life_fraction = frac_q;
      out_d.alive_total   = live_q;
      out_d.present       = 1'b1;
      out_d.last          = (i_q + 1'b1 == live_q);
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SEED0: begin mul_a = {1'b0, id_q}; mul_b = {1'b0, SEED_MUL[31:0]}; end
      S_SEED1: begin mul_a = {1'b0, id_q}; mul_b = {1'b0, SEED_MUL[63:32]}; end
      S_DEBT0: begin mul_a = {1'b0, dt_q}; mul_b = {rate_eff[31], rate_eff}; end
      S_L0:    begin mul_a = {1'b0, rng_q[31:0]}; mul_b = {1'b0, LCG_MUL[31:0]}; end
      S_L1:    begin mul_a = {1'b0, rng_q[31:0]}; mul_b = {1'b0, LCG_MUL[63:32]}; end
      S_L2:    begin mul_a = {1'b0, rng_q[63:32]}; mul_b = {1'b0, LCG_MUL[31:0]}; end
      S_R0:    begin mul_a = {9'd0, rng_q[63:40]}; mul_b = {1'b0, rspan[31:0]}; end
      S_J0:    begin mul_a = {{8{jx_q[24]}}, jx_q}; mul_b = {speed_q[31], speed_q}; end
      S_J1:    begin mul_a = {{8{jz_q[24]}}, jz_q}; mul_b = {speed_q[31], speed_q}; end
      S_GRAV0: begin mul_a = {grav_q[31], grav_q}; mul_b = {1'b0, dt_q}; end
      S_M0: begin
        mul_a = {ram_rdata.vel_x[31], ram_rdata.vel_x};
        mul_b = {1'b0, dt_q};
      end
      S_M1:    begin mul_a = {ent_q.vel_y[31], ent_q.vel_y}; mul_b = {1'b0, dt_q}; end
      S_M2:    begin mul_a = {ent_q.vel_z[31], ent_q.vel_z}; mul_b = {1'b0, dt_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Memory port control.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = i_q[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = k_q[IDX_W-1:0];
    ram_wdata = ent_q;
    unique case (state_q)
      S_CULL_RD: ram_re = (i_q < live_q);
      S_M_RD:    ram_re = 1'b1;
      S_CULL_WR: begin
        ram_we        = (cull_age < ram_rdata.life);
        ram_wdata     = ram_rdata;
        ram_wdata.age = cull_age;
      end
      S_J2: begin
        ram_we    = 1'b1;
        ram_waddr = live_q[IDX_W-1:0];
        ram_wdata = spawn_ent;
      end
      S_M4: begin
        ram_we    = 1'b1;
        ram_waddr = i_q[IDX_W-1:0];
      end
      default: begin
        ram_re = 1'b0;
        ram_we = 1'b0;
      end
    endcase
  end

  assign div_start = (state_q == S_M4) && (ent_q.life > 32'sd0) && (ent_q.age > 32'sd0)
                     && (ent_q.age < ent_q.life);

  ptcl_ram #(.WIDTH($bits(part_t)), .DEPTH(PART_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptcl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ptcl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ent_q.age[30:0]),
    .den_i   (ent_q.life[30:0]),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= 32'sd0;
      cap_q     <= 7'(PART_SLOTS);
      spd_lo_q  <= 32'sd0;
      spd_hi_q  <= 32'sd65536;
      life_lo_q <= 32'sd65536;
      life_hi_q <= 32'sd131072;
      grav_q    <= 32'sd0;
      id_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_EMIT_RATE:  rate_q    <= cfg_wdata_i;
        CFG_CAP:        cap_q     <= cfg_wdata_i[6:0];
        CFG_SPEED_LOW:  spd_lo_q  <= cfg_wdata_i;
        CFG_SPEED_HIGH: spd_hi_q  <= cfg_wdata_i;
        CFG_LIFE_LOW:   life_lo_q <= cfg_wdata_i;
        CFG_LIFE_HIGH:  life_hi_q <= cfg_wdata_i;
        CFG_GRAVITY:    grav_q    <= cfg_wdata_i;
        CFG_EMITTER_ID: id_q      <= cfg_wdata_i;
        default:        id_q      <= id_q;
      endcase
    end
  end

  // Tick sequencer with its state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      draw_q      <= D_SPEED;
      live_q      <= '0;
      debt_q      <= '0;
      rng_q       <= '0;
      seeded_q    <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            dt_q   <= in_data_i.dt[31] ? 32'sd0 : in_data_i.dt;
            emit_q <= in_data_i.emitting;
            ox_q   <= in_data_i.origin_x;
            oy_q   <= in_data_i.origin_y;
            oz_q   <= in_data_i.origin_z;
            i_q    <= '0;
            k_q    <= '0;
            state_q <= seeded_q ? S_CULL_RD : S_SEED0;
          end
        end
        S_SEED0: state_q <= S_SEED1;
        S_SEED1: begin
          acc_q   <= prod[63:0];
          state_q <= S_SEED2;
        end
        S_SEED2: begin
          rng_q    <= acc_q + {prod[31:0], 32'd0} + SEED_ADD;
          seeded_q <= 1'b1;
          state_q  <= S_CULL_RD;
        end
        S_CULL_RD: begin
          if (i_q < live_q) begin
            state_q <= S_CULL_WR;
          end else begin
            live_q  <= k_q;
            state_q <= S_DEBT0;
          end
        end
        S_CULL_WR: begin
          if (cull_age < ram_rdata.life) begin
            k_q <= k_q + 1'b1;
          end
          i_q     <= i_q + 1'b1;
          state_q <= S_CULL_RD;
        end
        S_DEBT0: state_q <= S_DEBT1;
        S_DEBT1: begin
          debt_q  <= debt_sum[48] ? DEBT_MAX : debt_sum[47:0];
          state_q <= S_SPAWN;
        end
        S_SPAWN: begin
          if (debt_q >= ONE_Q16 && live_q < cap_eff) begin
            debt_q  <= debt_q - ONE_Q16;
            draw_q  <= D_SPEED;
            state_q <= S_L0;
          end else begin
            if (live_q >= cap_eff && debt_q > ONE_Q16) begin
              debt_q <= '0;
            end
            i_q     <= '0;
            state_q <= (live_q == '0) ? S_EMPTY : S_GRAV0;
          end
        end
        S_L0: state_q <= S_L1;
        S_L1: begin
          acc_q   <= prod[63:0];
          state_q <= S_L2;
        end
        S_L2: begin
          acc_q   <= acc_q + {prod[31:0], 32'd0};
          state_q <= S_L3;
        end
        S_L3: begin
          rng_q <= rng_next;
          unique case (draw_q)
            D_SPEED, D_LIFE: state_q <= S_R0;
            D_JX: begin
              jx_q    <= $signed({1'b0, unit_next}) - 25'sh080_0000;
              draw_q  <= D_JZ;
              state_q <= S_L0;
            end
            D_JZ: begin
              jz_q    <= $signed({1'b0, unit_next}) - 25'sh080_0000;
              draw_q  <= D_LIFE;
              state_q <= S_L0;
            end
            default: state_q <= S_L0;
          endcase
        end
        S_R0: state_q <= S_R1;
        S_R1: begin
          if (draw_q == D_LIFE) begin
            life_q  <= rng_val;
            state_q <= S_J0;
          end else begin
            speed_q <= rng_val;
            draw_q  <= D_JX;
            state_q <= S_L0;
          end
        end
        S_J0: state_q <= S_J1;
        S_J1: begin
          vx_q    <= prod[56:25];
          state_q <= S_J2;
        end
        S_J2: begin
          live_q  <= live_q + 1'b1;
          state_q <= S_SPAWN;
        end
        S_GRAV0: state_q <= S_GRAV1;
        S_GRAV1: begin
          gdy_q   <= prod[63:16];
          state_q <= S_M_RD;
        end
        S_M_RD: state_q <= S_M0;
        S_M0: begin
          ent_q   <= ent_ld;
          state_q <= S_M1;
        end
        S_M1: begin
          ent_q.pos_x <= sat32(sext50(ent_q.pos_x) + prod[65:16]);
          state_q     <= S_M2;
        end
        S_M2: begin
          ent_q.pos_y <= sat32(sext50(ent_q.pos_y) + prod[65:16]);
          state_q     <= S_M3;
        end
        S_M3: begin
          ent_q.pos_z <= sat32(sext50(ent_q.pos_z) + prod[65:16]);
          state_q     <= S_M4;
        end
        S_M4: begin
          // A particle of positive age and lifetime at or past that lifetime reads as a full fraction.
          if (ent_q.life > 32'sd0 && ent_q.age > 32'sd0) begin
            frac_q  <= FRAC_ONE;
            state_q <= (ent_q.age < ent_q.life) ? S_DIVW : S_M_OUT;
          end else begin
            frac_q  <= '0;
            state_q <= S_M_OUT;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            frac_q  <= {1'b0, div_quot};
            state_q <= S_M_OUT;
          end
        end
        S_M_OUT: begin
          if (out_free) begin
            i_q     <= i_q + 1'b1;
            state_q <= (i_q + 1'b1 == live_q) ? S_IDLE : S_M_RD;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PTCL_ASSERT_ALWAYS(a_live_bound, live_q <= CNT_W'(PART_SLOTS), "live count above maximum")
  `PTCL_ASSERT_IMPL(a_spawn_cap, state_q == S_J2, live_q < cap_eff, "spawn beyond cap")
  `PTCL_ASSERT_IMPL(a_seed_first, state_q == S_CULL_RD, seeded_q, "cull before seeding")
  `PTCL_ASSERT_IMPL(a_div_owner, div_busy, state_q == S_DIVW, "divider busy outside wait")
  `PTCL_ASSERT_IMPL(a_out_load, $rose(out_valid_q),
                    $past(state_q == S_M_OUT || state_q == S_EMPTY), "stray output load")

endmodule
